### rtl/core/sdcsd_pkg.sv
// Shared types, constants and decode functions for the SD CSD register checker.
// No dependencies; used by all modules under rtl/core.
`default_nettype none

package sdcsd_pkg;

	localparam int unsigned REG_BYTES = 16;
	localparam int unsigned IDX_W = 4;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REG_BYTES - 1);
	localparam logic [IDX_W-1:0] IDX_STRUCT = 4'd0;
	localparam logic [IDX_W-1:0] IDX_SPEED = 4'd3;
	localparam logic [IDX_W-1:0] IDX_BLEN = 4'd5;

	localparam logic [7:0] STRUCT_MASK = 8'hC0;
	localparam logic [7:0] VER_ONE = 8'h00;
	localparam logic [7:0] VER_TWO = 8'h40;
	localparam logic [7:0] RSVD_MASK = 8'h3F;
	localparam logic [7:0] SPEED_NORMAL = 8'h32;
	localparam logic [7:0] SPEED_HIGH = 8'h5A;
	localparam logic [3:0] BLEN_V2 = 4'd9;
	localparam logic [3:0] BLEN_MIN = 4'd9;
	localparam logic [3:0] BLEN_MAX = 4'd11;
	localparam logic [2:0] UNIT_MAX = 3'd3;
	localparam logic [6:0] CRC_POLY = 7'h09;

	localparam int unsigned DATA_W = 8;
	localparam int unsigned OUT_W = 56;

	typedef enum logic [2:0] {
		STATUS_OK        = 3'd0,
		STATUS_CRC_FAIL  = 3'd1,
		STATUS_BAD_VER   = 3'd2,
		STATUS_RESERVED  = 3'd3,
		STATUS_SPEED     = 3'd4,
		STATUS_BLOCK_LEN = 3'd5
	} status_t;

	// captured CSD fields plus running CRC over bytes 0..14
	typedef struct packed {
		logic [7:0] structure;
		logic [7:0] speed;
		logic [3:0] blen_exp;
		logic [6:0] crc;
	} csd_ctx_t;

	typedef struct packed {
		logic [29:0] max_rate_hz;
		logic [15:0] block_length;
		logic        is_version_two;
		status_t     status;
	} csd_result_t;

	function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] b);
		logic [6:0] c;
		logic       fb;
		c = crc_in;
		for (int i = 7; i >= 0; i--) begin
			fb = c[6] ^ b[i];
			c = {c[5:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// time value in tenths times 10^4 Hz
	function automatic logic [19:0] rate_base(input logic [3:0] tv);
		logic [19:0] r;
		case (tv)
			4'd0:    r = 20'd0;
			4'd1:    r = 20'd100000;
			4'd2:    r = 20'd120000;
			4'd3:    r = 20'd130000;
			4'd4:    r = 20'd150000;
			4'd5:    r = 20'd200000;
			4'd6:    r = 20'd250000;
			4'd7:    r = 20'd300000;
			4'd8:    r = 20'd350000;
			4'd9:    r = 20'd400000;
			4'd10:   r = 20'd450000;
			4'd11:   r = 20'd500000;
			4'd12:   r = 20'd550000;
			4'd13:   r = 20'd600000;
			4'd14:   r = 20'd700000;
			4'd15:   r = 20'd800000;
			default: r = 20'd0;
		endcase
		return r;
	endfunction

	function automatic logic [9:0] unit_scale(input logic [2:0] unit);
		logic [9:0] s;
		case (unit)
			3'd0:    s = 10'd1;
			3'd1:    s = 10'd10;
			3'd2:    s = 10'd100;
			3'd3:    s = 10'd1000;
			default: s = 10'd0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

### rtl/core/sd_csd_register_checker.sv
// Top level of the SD CSD register checker: input register, tracker, checker, result register.
// Depends on sdcsd_pkg, sdcsd_track and sdcsd_check.
//
// Usage:
//   Feed the 16 CSD bytes, byte 0 first, one word per s_tvalid/s_tready
//   handshake. s_tuser marks byte 0 and restarts the count and CRC7; after
//   byte 15 the count wraps, so the next word is byte 0 even without it.
//   Bytes 0..14 give no output. Byte 15 gives one m_ word carrying status,
//   the version flag, block length and maximum rate in Hz.
//   Timing: a byte is registered in the input register at acceptance, and
//   its result word is registered in the result register when that
//   register is free, so m_tvalid rises once byte 15 has been taken in.
//   Throughput: one word per cycle unless byte 15 waits for a held result
//   word; the byte-wide CRC7 update lies between the input and CRC registers.
//   Stall: a held result word stalls only the final byte of the next
//   register; bytes 0..14 keep flowing into the tracker meanwhile.
//   Reset: arst_n clears byte count, CRC, captured fields and both valid
//   flags; no output is pending after reset.
`default_nettype none

module sd_csd_register_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [sdcsd_pkg::DATA_W-1:0]         s_tdata,  // [7:0] data_byte
	input  wire logic                                 s_tuser,  // [0] first_byte
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [sdcsd_pkg::OUT_W-1:0]               m_tdata   // [2:0] status,
	                                                            // [3] is_version_two,
	                                                            // [19:4] block_length,
	                                                            // [49:20] max_rate_hz
);
	import sdcsd_pkg::*;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        first_s1;
	logic        is_last;
	logic        out_free;
	logic        advance;
	csd_ctx_t    ctx;
	csd_result_t res;
	csd_result_t res_q;
	logic        out_valid_q;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!is_last || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	sdcsd_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.data_byte  (data_s1),
		.first_byte (first_s1),
		.ctx        (ctx),
		.is_last    (is_last)
	);

	sdcsd_check u_check (
		.ctx       (ctx),
		.last_byte (data_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_last) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, res_q};

endmodule

`default_nettype wire

### rtl/core/sdcsd_track.sv
// Byte position tracking, CRC7 accumulation and field capture for the CSD checker.
// Depends on sdcsd_pkg.
`default_nettype none

module sdcsd_track (
	input  wire                logic       clk,
	input  wire                logic       arst_n,
	input  wire                logic       advance,
	input  wire                logic [7:0] data_byte,
	input  wire                logic       first_byte,
	output sdcsd_pkg::csd_ctx_t            ctx,
	output logic                           is_last
);
	import sdcsd_pkg::*;

	logic [IDX_W-1:0] count_q;
	csd_ctx_t         ctx_q;
	logic [IDX_W-1:0] idx;
	logic [6:0]       crc_base;

	assign idx      = first_byte ? '0 : count_q;
	assign is_last  = (idx == LAST_IDX);
	assign crc_base = (idx == '0) ? '0 : ctx_q.crc;
	assign ctx      = ctx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ctx_q   <= '0;
		end else if (advance) begin
			if (is_last) begin
				count_q   <= '0;
				ctx_q.crc <= '0;
			end else begin
				count_q   <= idx + 1'b1;
				ctx_q.crc <= crc7_byte(crc_base, data_byte);
				if (idx == IDX_STRUCT) begin
					ctx_q.structure <= data_byte;
				end
				if (idx == IDX_SPEED) begin
					ctx_q.speed <= data_byte;
				end
				if (idx == IDX_BLEN) begin
					ctx_q.blen_exp <= data_byte[3:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/sdcsd_check.sv
// Validation and field decode of a complete CSD register on its final byte.
// Depends on sdcsd_pkg.
`default_nettype none

module sdcsd_check (
	input  sdcsd_pkg::csd_ctx_t    ctx,
	input  wire logic [7:0]        last_byte,
	output sdcsd_pkg::csd_result_t res
);
	import sdcsd_pkg::*;

	logic [7:0]  ver;
	logic        ver_ok;
	logic        blen_bad;
	logic [2:0]  unit;
	logic [29:0] rate;

	assign ver      = ctx.structure & STRUCT_MASK;
	assign ver_ok   = (ver == VER_ONE) || (ver == VER_TWO);
	assign blen_bad = ((ver == VER_ONE) && ((ctx.blen_exp < BLEN_MIN) || (ctx.blen_exp > BLEN_MAX)))
		|| ((ver == VER_TWO) && (ctx.blen_exp != BLEN_V2));
	assign unit     = ctx.speed[2:0];
	assign rate     = rate_base(ctx.speed[6:3]) * unit_scale(unit);

	always_comb begin
		if (ctx.crc != last_byte[7:1]) begin
			res.status = STATUS_CRC_FAIL;
		end else if (!ver_ok) begin
			res.status = STATUS_BAD_VER;
		end else if (!last_byte[0] || ((ctx.structure & RSVD_MASK) != '0)) begin
			res.status = STATUS_RESERVED;
		end else if ((ctx.speed != SPEED_NORMAL) && (ctx.speed != SPEED_HIGH)) begin
			res.status = STATUS_SPEED;
		end else if (blen_bad) begin
			res.status = STATUS_BLOCK_LEN;
		end else begin
			res.status = STATUS_OK;
		end
		res.is_version_two = (ver == VER_TWO);
		res.block_length   = 16'(17'd1 << ctx.blen_exp);
		res.max_rate_hz    = (unit > UNIT_MAX) ? '0 : rate;
	end

endmodule

`default_nettype wire
